// ===== rtl/core/ocq_pkg.sv =====
// Ordered queue package: field widths, status codes and the cell control bundle.
// No dependencies; used by ocq_cell and ordered_queue_delete_by_key.
package ocq_pkg;

  localparam int unsigned KeyW  = 14;
  localparam int unsigned PosW  = 6;
  localparam int unsigned OccW  = 7;
  localparam int unsigned InW   = 16;
  localparam int unsigned OutW  = 16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef struct packed {
    logic            capture;     // compare key against entry, register match
    logic            ins_commit;  // tail cell loads key
    logic            rem_commit;  // cells at and behind the hit pull from neighbor
    logic [KeyW-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ocq_cell.sv =====
// One queue slot: holds a key, registers its match flag and shifts toward the head.
// Depends on ocq_pkg.
module ocq_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ocq_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     in_range_i,
  input  logic                     tail_i,
  input  logic                     hit_i,
  output logic                     hit_o,
  output logic                     first_o,
  input  logic [ocq_pkg::KeyW-1:0] next_entry_i,
  output logic [ocq_pkg::KeyW-1:0] entry_o
);
  import ocq_pkg::*;

  logic [KeyW-1:0] entry_q;
  logic            match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      match_q <= in_range_i && (entry_q == ctrl_i.key);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_commit && tail_i) begin
      entry_q <= ctrl_i.key;
    end else if (ctrl_i.rem_commit && hit_o) begin
      entry_q <= next_entry_i;
    end
  end

  assign hit_o   = hit_i | match_q;
  assign first_o = match_q & ~hit_i;
  assign entry_o = entry_q;

endmodule

// ===== rtl/core/ordered_queue_delete_by_key.sv =====
// Ordered key queue with delete-by-key, top level.
// Depends on ocq_pkg and ocq_cell.
//
// Usage:
//   Requests enter on the s_axis channel: bit 0 is the operation (0 insert at
//   tail, 1 remove first matching key), bits 14:1 the plate key. Every request
//   yields one result on m_axis: status, the removed key's former position
//   (entries ahead of it, 0 unless a remove succeeded) and the new occupancy.
//   The queue is a row of DEPTH cells. In the accept cycle every cell compares
//   the key against its slot; in the commit cycle, once the output register is
//   free, the first hit is resolved along the chain, the hit cell and all cells
//   behind it take their neighbor's key, and the result is loaded into the
//   output register. A new request is not accepted until the prior one has
//   committed. A request is accepted while a prior
//   result still waits, but its commit holds until the output register frees.
//   Reset empties the queue (occupancy 0); slot contents are not cleared.
//   A stalled receiver holds the result stable and stalls further requests.
module ordered_queue_delete_by_key #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [ocq_pkg::InW-1:0]   s_axis_tdata,   // [0] operation, [14:1] plate_key
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [ocq_pkg::OutW-1:0]  m_axis_tdata    // [1:0] status, [7:2] position,
                                                    // [14:8] occupancy
);
  import ocq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            op_q;
  logic [KeyW-1:0] key_q;
  logic            out_valid_q, out_valid_d;
  logic [OutW-1:0] out_data_q, out_data_d;

  logic            accept, commit, out_free;
  cell_ctrl_t      ctrl;
  logic [DEPTH-1:0] in_range, tail, hit, first;
  logic [KeyW-1:0]  entry [DEPTH];
  logic [IdxW-1:0]  hit_pos;
  status_e          status;
  logic             any_hit, is_full, is_empty;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign commit        = (state_q == S_EXEC) && out_free;

  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign any_hit  = hit[DEPTH-1];

  always_comb begin
    ctrl.capture    = accept;
    ctrl.key        = accept ? s_axis_tdata[KeyW:1] : key_q;
    ctrl.ins_commit = commit && (op_q == OP_INSERT) && !is_full;
    ctrl.rem_commit = commit && (op_q == OP_REMOVE) && any_hit;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign in_range[i] = CntW'(i) < count_q;
    assign tail[i]     = CntW'(i) == count_q;

    ocq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .in_range_i   (in_range[i]),
      .tail_i       (tail[i]),
      .hit_i        ((i == 0) ? 1'b0 : hit[(i == 0) ? 0 : i - 1]),
      .hit_o        (hit[i]),
      .first_o      (first[i]),
      .next_entry_i (entry[(i == DEPTH - 1) ? i : i + 1]),
      .entry_o      (entry[i])
    );
  end

  always_comb begin
    hit_pos = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      hit_pos = hit_pos | (first[i] ? IdxW'(i) : '0);
    end
  end

  always_comb begin
    status  = ST_OK;
    count_d = count_q;
    if (op_q == OP_INSERT) begin
      if (is_full) begin
        status = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      priority if (is_empty) begin
        status = ST_EMPTY;
      end else if (!any_hit) begin
        status = ST_NOT_FOUND;
      end else begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, OccW'(count_d),
                         ((op_q == OP_REMOVE) && any_hit) ? PosW'(hit_pos) : PosW'(0),
                         status};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      op_q  <= s_axis_tdata[0];
      key_q <= s_axis_tdata[KeyW:1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
